/* hdl/mre_pkg.sv */
package mre_pkg;

  // report framing characters
  localparam logic [7:0] ESC_CHAR      = 8'd27;
  localparam logic [7:0] BRACKET_CHAR  = 8'h5B;
  localparam logic [7:0] M_CHAR        = 8'h4D;

  // button byte pieces
  localparam logic [7:0] BTN_BASE      = 8'd32;
  localparam logic [7:0] MOTION_ADD    = 8'd32;
  localparam logic [7:0] WHEEL_ADD     = 8'd64;
  localparam logic [7:0] COORD_OFFSET  = 8'd33;
  localparam logic [7:0] COORD_MAX     = 8'd255;
  localparam logic [6:0] WHEEL_MASK    = 7'h18;

  // modifier pattern that suppresses reports
  localparam logic [2:0] MOD_SHIFT_ONLY = 3'b001;

  // reset values of the configuration registers
  localparam logic [7:0] WIDTH_RESET   = 8'd80;
  localparam logic [7:0] HEIGHT_RESET  = 8'd24;

  // bit positions
  localparam int BTN_LEFT    = 0;
  localparam int BTN_MIDDLE  = 1;
  localparam int BTN_RIGHT   = 2;
  localparam int BTN_WHUP    = 3;
  localparam int BTN_WHDOWN  = 4;
  localparam int MOD_SHIFT   = 0;
  localparam int MOD_CTRL    = 1;
  localparam int MOD_META    = 2;

  typedef enum logic [1:0] {
    TRACK_NONE   = 2'd0,
    TRACK_PRESS  = 2'd1,
    TRACK_BUTTON = 2'd2,
    TRACK_ANY    = 2'd3
  } track_mode_t;

  typedef enum logic [1:0] {
    CFG_TRACK_MODE    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    BYTE_ESC     = 3'd0,
    BYTE_BRACKET = 3'd1,
    BYTE_M       = 3'd2,
    BYTE_BUTTON  = 3'd3,
    BYTE_X       = 3'd4,
    BYTE_Y       = 3'd5
  } byte_sel_t;

  // one pending report: the three bytes that vary
  typedef struct packed {
    logic [7:0] btn_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } frame_t;

endpackage

/* hdl/mre_fifo.sv */
module mre_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mre_pkg::frame_t wr_data,
  input  logic            rd_en,
  output mre_pkg::frame_t rd_data,
  output logic            full,
  output logic            not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mre_pkg::frame_t   entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/mre_front.sv */
module mre_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [15:0]     pos_x,
  input  logic [15:0]     pos_y,
  input  logic [6:0]      buttons,
  input  logic [2:0]      modifiers,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  output logic            q_push,
  output mre_pkg::frame_t q_data
);

  mre_pkg::track_mode_t track_mode;
  logic [7:0]           screen_width;
  logic [7:0]           screen_height;
  logic [8:0]           prev_x;
  logic [8:0]           prev_y;
  logic [6:0]           prev_buttons;

  logic [7:0] x_clamp;
  logic [7:0] y_clamp;
  logic [8:0] x_sum;
  logic [8:0] y_sum;
  logic       moved;
  logic [6:0] change;
  logic [6:0] pressed;
  logic [6:0] released;
  logic [6:0] btn_next;
  logic [7:0] base;
  logic [7:0] btn_byte;
  logic       emit;

  // clamp position into the screen
  always_comb begin
    if (pos_x[15]) begin
      x_clamp = '0;
    end else if (pos_x > {8'd0, screen_width}) begin
      x_clamp = screen_width;
    end else begin
      x_clamp = pos_x[7:0];
    end
    if (pos_y[15]) begin
      y_clamp = '0;
    end else if (pos_y > {8'd0, screen_height}) begin
      y_clamp = screen_height;
    end else begin
      y_clamp = pos_y[7:0];
    end
  end

  // coordinate bytes saturate at the top of the byte range
  assign x_sum = {1'b0, x_clamp} + {1'b0, mre_pkg::COORD_OFFSET};
  assign y_sum = {1'b0, y_clamp} + {1'b0, mre_pkg::COORD_OFFSET};

  assign moved    = ({1'b0, x_clamp} != prev_x) || ({1'b0, y_clamp} != prev_y);
  assign change   = prev_buttons ^ buttons;
  assign pressed  = buttons & change;
  assign released = ~buttons & change;
  assign btn_next = buttons & ~mre_pkg::WHEEL_MASK;

  assign base = mre_pkg::BTN_BASE
              | {3'd0, modifiers[mre_pkg::MOD_CTRL], 4'd0}
              | {4'd0, modifiers[mre_pkg::MOD_META], 3'd0}
              | {5'd0, modifiers[mre_pkg::MOD_SHIFT], 2'd0};

  // classify the event into a button byte or nothing
  always_comb begin
    emit     = 1'b0;
    btn_byte = base;
    if (track_mode != mre_pkg::TRACK_NONE && modifiers != mre_pkg::MOD_SHIFT_ONLY) begin
      if (change != '0) begin
        emit = 1'b1;
        priority if (pressed[mre_pkg::BTN_LEFT]) begin
          btn_byte = base;
        end else if (pressed[mre_pkg::BTN_MIDDLE]) begin
          btn_byte = base + 8'd1;
        end else if (pressed[mre_pkg::BTN_RIGHT]) begin
          btn_byte = base + 8'd2;
        end else if (pressed[mre_pkg::BTN_WHUP]) begin
          btn_byte = base + mre_pkg::WHEEL_ADD;
        end else if (pressed[mre_pkg::BTN_WHDOWN]) begin
          btn_byte = base + mre_pkg::WHEEL_ADD + 8'd1;
        end else if (released != '0) begin
          btn_byte = base + 8'd3;
        end else begin
          emit = 1'b0;
        end
      end else if (moved && (track_mode == mre_pkg::TRACK_ANY ||
                             (track_mode == mre_pkg::TRACK_BUTTON && btn_next != '0))) begin
        emit = 1'b1;
        priority if (btn_next[mre_pkg::BTN_LEFT]) begin
          btn_byte = base + mre_pkg::MOTION_ADD;
        end else if (btn_next[mre_pkg::BTN_MIDDLE]) begin
          btn_byte = base + mre_pkg::MOTION_ADD + 8'd1;
        end else if (btn_next[mre_pkg::BTN_RIGHT]) begin
          btn_byte = base + mre_pkg::MOTION_ADD + 8'd2;
        end else begin
          btn_byte = base + mre_pkg::MOTION_ADD + 8'd3;
        end
      end
    end
  end

  assign q_push          = accept && emit;
  assign q_data.btn_byte = btn_byte;
  assign q_data.x_byte   = x_sum[8] ? mre_pkg::COORD_MAX : x_sum[7:0];
  assign q_data.y_byte   = y_sum[8] ? mre_pkg::COORD_MAX : y_sum[7:0];

  // configuration registers and tracked pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      track_mode    <= mre_pkg::TRACK_NONE;
      screen_width  <= mre_pkg::WIDTH_RESET;
      screen_height <= mre_pkg::HEIGHT_RESET;
      prev_x        <= '1;
      prev_y        <= '1;
      prev_buttons  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mre_pkg::CFG_TRACK_MODE:    track_mode    <= mre_pkg::track_mode_t'(cfg_data[1:0]);
          mre_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          mre_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev_x       <= {1'b0, x_clamp};
        prev_y       <= {1'b0, y_clamp};
        prev_buttons <= btn_next;
      end
    end
  end

endmodule

/* hdl/mre_back.sv */
module mre_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_ready,
  input  mre_pkg::frame_t q_data,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      report_byte,
  output logic            last_byte
);

  mre_pkg::frame_t      frame;
  mre_pkg::byte_sel_t   sel;
  mre_pkg::byte_sel_t   sel_next;
  logic                 busy;
  logic                 done;

  assign done  = busy && pop && (sel == mre_pkg::BYTE_Y);
  assign q_pop = q_ready && (!busy || done);
  assign empty = !busy;

  // byte select for the word on the output
  always_comb begin
    last_byte   = 1'b0;
    sel_next    = sel;
    unique case (sel)
      mre_pkg::BYTE_ESC: begin
        report_byte = mre_pkg::ESC_CHAR;
        sel_next    = mre_pkg::BYTE_BRACKET;
      end
      mre_pkg::BYTE_BRACKET: begin
        report_byte = mre_pkg::BRACKET_CHAR;
        sel_next    = mre_pkg::BYTE_M;
      end
      mre_pkg::BYTE_M: begin
        report_byte = mre_pkg::M_CHAR;
        sel_next    = mre_pkg::BYTE_BUTTON;
      end
      mre_pkg::BYTE_BUTTON: begin
        report_byte = frame.btn_byte;
        sel_next    = mre_pkg::BYTE_X;
      end
      mre_pkg::BYTE_X: begin
        report_byte = frame.x_byte;
        sel_next    = mre_pkg::BYTE_Y;
      end
      mre_pkg::BYTE_Y: begin
        report_byte = frame.y_byte;
        last_byte   = 1'b1;
        sel_next    = mre_pkg::BYTE_ESC;
      end
      default: begin
        report_byte = mre_pkg::ESC_CHAR;
        sel_next    = mre_pkg::BYTE_ESC;
      end
    endcase
  end

  // frame register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame <= q_data;
    end
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= mre_pkg::BYTE_ESC;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        sel  <= mre_pkg::BYTE_ESC;
      end else if (done) begin
        busy <= 1'b0;
        sel  <= mre_pkg::BYTE_ESC;
      end else if (busy && pop) begin
        sel  <= sel_next;
      end
    end
  end

endmodule

/* hdl/mouse_report_encoder_core.sv */
// channel   direction  handshake                 payload
// events    in         push / full               pos_x, pos_y, buttons, modifiers
// reports   out        pop / empty               report_byte, last_byte
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// an event is classified in the cycle it is taken; one event per cycle is
// taken while the report queue (QUEUE_DEPTH frames) has room.
// each report is six words, one per cycle while pop is held, set by the
// byte serializer; when the serializer is idle, the first word shows on the
// output once its frame has passed through the queue and the frame register.
// full holds off all events, reporting or not, while the queue is full.
// synchronous reset clears the queue, the serializer and the tracked state.
module mouse_report_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [6:0]  buttons,
  input  logic [2:0]  modifiers,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  report_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic            accept;
  logic            q_push;
  logic            q_pop;
  logic            q_ready;
  mre_pkg::frame_t q_wr_data;
  mre_pkg::frame_t q_rd_data;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // event classification
  mre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .buttons   (buttons),
    .modifiers (modifiers),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // pending report frames
  mre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_push),
    .wr_data   (q_wr_data),
    .rd_en     (q_pop),
    .rd_data   (q_rd_data),
    .full      (full),
    .not_empty (q_ready)
  );

  // report serializer
  mre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_ready     (q_ready),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .report_byte (report_byte),
    .last_byte   (last_byte)
  );

endmodule

/* hdl/mre_checker.sv */
module mre_checker (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic [7:0] report_byte,
  input logic       last_byte
);

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // a report is never cut short once it has started
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_byte) |=> !empty)
    else $error("report broken off before its last word");

  // escape opens a report and is followed by the bracket
  a_esc_then_bracket: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && report_byte == mre_pkg::ESC_CHAR) |=>
      (report_byte == mre_pkg::BRACKET_CHAR && !last_byte))
    else $error("escape not followed by bracket");

  // a waiting word holds while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(report_byte) && $stable(last_byte)))
    else $error("waiting word changed while stalled");

endmodule

bind mouse_report_encoder_core mre_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pop         (pop),
  .empty       (empty),
  .report_byte (report_byte),
  .last_byte   (last_byte)
);

/* bench/mouse_report_encoder_core_tb.sv */
`timescale 1ns / 100ps

module mouse_report_encoder_core_tb;

  // button byte pieces that the package leaves as plain numbers
  localparam logic [7:0] CTRL_ADD        = 8'd16;
  localparam logic [7:0] META_ADD        = 8'd8;
  localparam logic [7:0] SHIFT_ADD       = 8'd4;
  localparam logic [7:0] CODE_LEFT       = 8'd0;
  localparam logic [7:0] CODE_MIDDLE     = 8'd1;
  localparam logic [7:0] CODE_RIGHT      = 8'd2;
  localparam logic [7:0] CODE_RELEASE    = 8'd3;
  localparam logic [7:0] WHEEL_UP_CODE   = mre_pkg::WHEEL_ADD;
  localparam logic [7:0] WHEEL_DOWN_CODE = mre_pkg::WHEEL_ADD + 8'd1;
  localparam int         NUM_PHASES      = 8;
  localparam int         PHASE_EVENTS    = 52;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [6:0]         btn;
    logic [2:0]         mods;
  } mouse_event_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } report_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic [6:0]  buttons = '0;
  logic [2:0]  modifiers = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  report_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  mouse_report_encoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .buttons     (buttons),
    .modifiers   (modifiers),
    .empty       (empty),
    .pop         (pop),
    .report_byte (report_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // encoder state mirrored by the bench
  mre_pkg::track_mode_t trk;
  logic [7:0]  scr_w;
  logic [7:0]  scr_h;
  int          last_x;
  int          last_y;
  logic [6:0]  last_btn;

  mouse_event_t mouse_events_q[$];
  report_word_t report_bytes_q[$];

  bit ev_taken = 1'b0;
  bit steady_flow = 1'b0;
  int send_gap = 0;
  int pop_stall = 0;
  int errors = 0;
  int events_taken = 0;
  int words_checked = 0;
  int reports_predicted = 0;
  int regs_written = 0;

  // random walk of the pointer and buttons
  int         gen_x;
  int         gen_y;
  logic [6:0] gen_btn;

  mre_pkg::track_mode_t phase_track [NUM_PHASES] = '{
    mre_pkg::TRACK_ANY, mre_pkg::TRACK_BUTTON, mre_pkg::TRACK_PRESS, mre_pkg::TRACK_ANY,
    mre_pkg::TRACK_NONE, mre_pkg::TRACK_BUTTON, mre_pkg::TRACK_ANY, mre_pkg::TRACK_PRESS};

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t ns: %s", $time, msg);
  endfunction

  function automatic int clamp_coord(logic signed [15:0] v, logic [7:0] hi);
    if (v < 0) return 0;
    if (int'(v) > int'(hi)) return int'(hi);
    return int'(v);
  endfunction

  function automatic logic [7:0] coord_byte(int c);
    int v = c + int'(mre_pkg::COORD_OFFSET);
    return (v > int'(mre_pkg::COORD_MAX)) ? mre_pkg::COORD_MAX : v[7:0];
  endfunction

  // work out the report words that one event causes
  function automatic void encode_mouse_event(mouse_event_t ev);
    int         cx;
    int         cy;
    bit         moved;
    bit         emit;
    logic [6:0] change;
    logic [6:0] pressed;
    logic [6:0] released;
    logic [7:0] base;
    logic [7:0] code;
    cx = clamp_coord(ev.x, scr_w);
    cy = clamp_coord(ev.y, scr_h);
    moved = (cx != last_x) || (cy != last_y);
    change = last_btn ^ ev.btn;
    pressed = ev.btn & change;
    released = ~ev.btn & change;
    last_x = cx;
    last_y = cy;
    last_btn = ev.btn & ~mre_pkg::WHEEL_MASK;
    if (trk == mre_pkg::TRACK_NONE || ev.mods == mre_pkg::MOD_SHIFT_ONLY) return;

    base = mre_pkg::BTN_BASE;
    if (ev.mods[mre_pkg::MOD_CTRL]) base += CTRL_ADD;
    if (ev.mods[mre_pkg::MOD_META]) base += META_ADD;
    if (ev.mods[mre_pkg::MOD_SHIFT]) base += SHIFT_ADD;
    emit = 1'b1;
    code = base;
    if (change != 0) begin
      if (pressed[mre_pkg::BTN_LEFT]) code = base + CODE_LEFT;
      else if (pressed[mre_pkg::BTN_MIDDLE]) code = base + CODE_MIDDLE;
      else if (pressed[mre_pkg::BTN_RIGHT]) code = base + CODE_RIGHT;
      else if (pressed[mre_pkg::BTN_WHUP]) code = base + WHEEL_UP_CODE;
      else if (pressed[mre_pkg::BTN_WHDOWN]) code = base + WHEEL_DOWN_CODE;
      else if (released != 0) code = base + CODE_RELEASE;
      else emit = 1'b0;
    end else if (moved && (trk == mre_pkg::TRACK_ANY ||
                           (trk == mre_pkg::TRACK_BUTTON && last_btn != 0))) begin
      code = base + mre_pkg::MOTION_ADD;
      if (last_btn[mre_pkg::BTN_LEFT]) code += CODE_LEFT;
      else if (last_btn[mre_pkg::BTN_MIDDLE]) code += CODE_MIDDLE;
      else if (last_btn[mre_pkg::BTN_RIGHT]) code += CODE_RIGHT;
      else code += CODE_RELEASE;
    end else begin
      emit = 1'b0;
    end
    if (!emit) return;

    reports_predicted++;
    report_bytes_q.push_back('{mre_pkg::ESC_CHAR, 1'b0});
    report_bytes_q.push_back('{mre_pkg::BRACKET_CHAR, 1'b0});
    report_bytes_q.push_back('{mre_pkg::M_CHAR, 1'b0});
    report_bytes_q.push_back('{code, 1'b0});
    report_bytes_q.push_back('{coord_byte(cx), 1'b0});
    report_bytes_q.push_back('{coord_byte(cy), 1'b1});
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly small pointer steps and single button toggles, now and then raw noise
  function automatic mouse_event_t random_event(int w, int h);
    mouse_event_t ev;
    int           b;
    if ($urandom_range(0, 99) < 8) begin
      ev.x = 16'($urandom);
      ev.y = 16'($urandom);
      ev.btn = 7'($urandom);
      ev.mods = 3'($urandom);
      gen_btn = ev.btn & ~mre_pkg::WHEEL_MASK;
      return ev;
    end
    if ($urandom_range(0, 1)) begin
      gen_x += int'($urandom_range(0, 6)) - 3;
      gen_y += int'($urandom_range(0, 6)) - 3;
      if (gen_x < -3) gen_x = -3;
      if (gen_x > w + 3) gen_x = w + 3;
      if (gen_y < -3) gen_y = -3;
      if (gen_y > h + 3) gen_y = h + 3;
    end
    if ($urandom_range(0, 99) < 35) begin
      b = $urandom_range(0, 8);
      if (b > 6) b -= 7;
      gen_btn[b] = ~gen_btn[b];
    end
    ev.x = gen_x[15:0];
    ev.y = gen_y[15:0];
    ev.btn = gen_btn;
    ev.mods = ($urandom_range(0, 99) < 65) ? 3'd0 : 3'($urandom_range(0, 7));
    // the wheel only pulses
    gen_btn &= ~mre_pkg::WHEEL_MASK;
    return ev;
  endfunction

  task automatic add_event(int x, int y, logic [6:0] btn, logic [2:0] mods);
    mouse_event_t ev;
    ev.x = 16'(x);
    ev.y = 16'(y);
    ev.btn = btn;
    ev.mods = mods;
    mouse_events_q.push_back(ev);
  endtask

  task automatic write_reg(mre_pkg::cfg_index_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    regs_written++;
  endtask

  task automatic set_screen(mre_pkg::track_mode_t mode, logic [7:0] w, logic [7:0] h);
    write_reg(mre_pkg::CFG_TRACK_MODE, 8'(mode));
    write_reg(mre_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(mre_pkg::CFG_SCREEN_HEIGHT, h);
  endtask

  // hold until every event is taken and every report word has come out
  task automatic drain(int settle);
    while (mouse_events_q.size() != 0 || push || report_bytes_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // event driver
  always @(negedge clk) begin : event_drive
    mouse_event_t cur;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || ev_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (mouse_events_q.size() != 0) begin
        cur = mouse_events_q.pop_front();
        pos_x <= cur.x;
        pos_y <= cur.y;
        buttons <= cur.btn;
        modifiers <= cur.mods;
        push <= 1'b1;
        send_gap = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // report reader with random stalls
  always @(negedge clk) begin : report_drain
    int r;
    if (rst) begin
      pop <= 1'b0;
    end else if (steady_flow) begin
      pop <= 1'b1;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        pop <= 1'b1;
      end else begin
        pop_stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        pop <= 1'b0;
      end
    end
  end

  // prediction on accepted events and writes, checking of report words
  always @(posedge clk) begin : report_check
    report_word_t want;
    ev_taken <= !rst && push && !full;
    if (!rst && cfg_valid && cfg_ready) begin
      case (mre_pkg::cfg_index_t'(cfg_index))
        mre_pkg::CFG_TRACK_MODE:    trk = mre_pkg::track_mode_t'(cfg_data[1:0]);
        mre_pkg::CFG_SCREEN_WIDTH:  scr_w = cfg_data;
        mre_pkg::CFG_SCREEN_HEIGHT: scr_h = cfg_data;
        default: ;
      endcase
    end
    if (!rst && push && !full) begin
      encode_mouse_event('{pos_x, pos_y, buttons, modifiers});
      events_taken++;
    end
    if (!rst && pop && !empty) begin
      words_checked++;
      if (report_bytes_q.size() == 0) begin
        log_error($sformatf("unexpected word %h last %b", report_byte, last_byte));
      end else begin
        want = report_bytes_q.pop_front();
        if (report_byte !== want.data)
          log_error($sformatf("report_byte expected %h got %h", want.data, report_byte));
        if (last_byte !== want.last)
          log_error($sformatf("last_byte expected %b got %b", want.last, last_byte));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [7:0] w;
    logic [7:0] h;
    trk = mre_pkg::TRACK_NONE;
    scr_w = mre_pkg::WIDTH_RESET;
    scr_h = mre_pkg::HEIGHT_RESET;
    last_x = -1;
    last_y = -1;
    last_btn = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tracking off after reset: presses stay silent
    add_event(5, 5, 7'h01, 3'd0);
    add_event(9, 3, 7'h00, 3'd0);
    drain(10);

    // largest screen: saturation, every button code, modifier mixes
    set_screen(mre_pkg::TRACK_ANY, 8'd255, 8'd255);
    add_event(-32768, -32768, 7'h00, 3'd0);
    add_event(32767, 32767, 7'h01, 3'd0);
    add_event(32767, 32767, 7'h01, 3'd6);
    add_event(100, 200, 7'h01, 3'd2);
    add_event(100, 200, 7'h03, 3'd4);
    add_event(100, 200, 7'h07, 3'd7);
    add_event(100, 200, 7'h0F, 3'd0);
    add_event(100, 200, 7'h17, 3'd0);
    add_event(100, 200, 7'h27, 3'd0);
    add_event(100, 200, 7'h67, 3'd0);
    add_event(100, 200, 7'h00, 3'd0);
    add_event(101, 200, 7'h01, 3'd1);
    add_event(101, 201, 7'h00, 3'd5);
    add_event(-1, 255, 7'h00, 3'd3);
    drain(10);

    // press/release only: motion and drags are quiet
    write_reg(mre_pkg::CFG_TRACK_MODE, 8'(mre_pkg::TRACK_PRESS));
    add_event(90, 30, 7'h00, 3'd0);
    add_event(90, 30, 7'h02, 3'd0);
    add_event(10, 10, 7'h02, 3'd0);
    drain(10);

    // zero-size screen collapses every position onto the origin
    set_screen(mre_pkg::TRACK_BUTTON, 8'd0, 8'd0);
    add_event(7, 7, 7'h00, 3'd0);
    add_event(3, -4, 7'h04, 3'd0);
    add_event(500, 500, 7'h04, 3'd0);
    drain(10);

    // button-motion mode with a button held
    set_screen(mre_pkg::TRACK_BUTTON, 8'd1, 8'd1);
    add_event(1, 1, 7'h04, 3'd0);
    add_event(0, 0, 7'h00, 3'd0);
    drain(10);

    // random phases, each after the previous one has fully drained
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (p == 1) ? 8'd1 : (p == 2) ? 8'd255 : 8'($urandom_range(1, 255));
      h = (p == 5) ? 8'd1 : (p == 3) ? 8'd255 : 8'($urandom_range(1, 255));
      set_screen(phase_track[p], w, h);
      steady_flow = (p == 2 || p == 5);
      gen_x = $urandom_range(0, int'(w));
      gen_y = $urandom_range(0, int'(h));
      gen_btn = '0;
      for (int i = 0; i < PHASE_EVENTS; i++) mouse_events_q.push_back(random_event(w, h));
      drain(10);
      steady_flow = 1'b0;
    end

    drain(30);
    if (report_bytes_q.size() != 0) log_error("report words still outstanding");
    $display("covered %0d events, %0d reports, %0d words checked, %0d register writes",
             events_taken, reports_predicted, words_checked, regs_written);
    $display("all tracking modes, screens from 0x0 to 255x255, wheel and modifier cases");
    if (errors == 0) begin
      $display("** mouse_report_encoder_core: PASSED **");
    end else begin
      $display("%0d errors", errors);
      $display("** mouse_report_encoder_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #3_000_000;
    $display("** mouse_report_encoder_core: FAILED **");
    $finish;
  end

endmodule
